[rtl/core/rltc_pkg.sv]
// Package for the run-length text codec: character codes, register map,
// default sizes and elaboration-time helpers. No dependencies.
package rltc_pkg;

  // Default saturation limit of a run or a repeat count.
  localparam int MAX_RUN_DEF = 1024;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Width of the repeat field in a result word.
  localparam int REP_W = 11;

  // ASCII codes of the decimal digits.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Register map and mode codes.
  localparam int         REG_MODE      = 0;
  localparam logic [0:0] MODE_COMPRESS = 1'b0;
  localparam logic [0:0] MODE_EXPAND   = 1'b1;

  // Number of decimal digits of a positive constant.
  function automatic int num_digits(input int v);
    int n;
    int x;
    n = 1;
    x = v;
    for (int i = 0; i < 10; i++) begin
      if (x >= 10) begin
        x = x / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Ten to the power k, for small constant k.
  function automatic int pow10(input int k);
    int p;
    p = 1;
    for (int i = 0; i < 9; i++) begin
      if (i < k) begin
        p = p * 10;
      end
    end
    return p;
  endfunction

endpackage

[rtl/core/rltc_queue.sv]
// Small register-based queue that carries commands from the front part to
// the back part. Depends on nothing but its parameters.
module rltc_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         not_empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNTW'(DEPTH));
  assign head_data = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && not_empty;

  // Pointer and fill-count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only the fill count marks valid slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/rltc_front.sv]
// Front part of the run-length text codec: holds the mode register and the
// run or count state, and turns each input word into a command. Uses rltc_pkg.
module rltc_front
  import rltc_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int CW      = $clog2(MAX_RUN + 1),
  parameter int ND      = num_digits(MAX_RUN),
  parameter int DW      = $clog2(ND + 1),
  parameter int CMD_W   = 18 + CW + DW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_mode,
  output logic             mode,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_symbol,
  input  logic             in_line_end,
  input  logic             q_full,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data
);

  localparam int AW = CW + 4;

  // One command: a run or a literal, and an optional single trailing char.
  typedef struct packed {
    logic          run;
    logic [7:0]    a_char;
    logic [CW-1:0] a_len;
    logic [DW-1:0] a_ndig;
    logic          b_valid;
    logic [7:0]    b_char;
  } cmd_t;

  logic          mode_r;
  logic [7:0]    prev_r, prev_nxt;
  logic          have_r, have_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          accept;
  logic          is_digit;
  logic [AW-1:0] acc;
  cmd_t          cmd;
  logic          emit;

  assign mode     = mode_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;
  assign q_data   = cmd;

  assign is_digit = (in_symbol >= CHAR_ZERO) && (in_symbol <= CHAR_NINE);

  // Next decimal count in expand mode, saturated at the run limit.
  always_comb begin
    acc = AW'(count_r) * AW'(10) + AW'(in_symbol - CHAR_ZERO);
    if (acc > AW'(MAX_RUN)) begin
      acc = AW'(MAX_RUN);
    end
  end

  // Classify the word and build its command and the next state.
  always_comb begin
    cmd       = '0;
    emit      = 1'b0;
    prev_nxt  = prev_r;
    have_nxt  = have_r;
    count_nxt = count_r;
    if (mode_r == MODE_COMPRESS) begin
      cmd.run = 1'b1;
      if (!have_r) begin
        prev_nxt  = in_symbol;
        count_nxt = CW'(1);
        have_nxt  = 1'b1;
        if (in_line_end) begin
          emit       = 1'b1;
          cmd.a_char = in_symbol;
          cmd.a_len  = CW'(1);
        end
      end else if (in_symbol == prev_r) begin
        if (count_r >= CW'(MAX_RUN)) begin
          // Saturated run goes out; this word opens a new run of one.
          emit        = 1'b1;
          cmd.a_char  = prev_r;
          cmd.a_len   = CW'(MAX_RUN);
          cmd.b_valid = in_line_end;
          cmd.b_char  = prev_r;
          count_nxt   = CW'(1);
        end else begin
          count_nxt = count_r + CW'(1);
          if (in_line_end) begin
            emit       = 1'b1;
            cmd.a_char = prev_r;
            cmd.a_len  = count_r + CW'(1);
          end
        end
      end else begin
        emit        = 1'b1;
        cmd.a_char  = prev_r;
        cmd.a_len   = count_r;
        cmd.b_valid = in_line_end;
        cmd.b_char  = in_symbol;
        prev_nxt    = in_symbol;
        count_nxt   = CW'(1);
      end
    end else begin
      if (is_digit) begin
        count_nxt = CW'(acc);
        have_nxt  = 1'b1;
      end else begin
        cmd.a_char = in_symbol;
        if (!have_r) begin
          emit      = 1'b1;
          cmd.a_len = CW'(1);
        end else if (count_r != '0) begin
          emit      = 1'b1;
          cmd.a_len = count_r;
        end
        have_nxt  = 1'b0;
        count_nxt = '0;
      end
    end
    if (in_line_end) begin
      prev_nxt  = '0;
      have_nxt  = 1'b0;
      count_nxt = '0;
    end
    // Digit count of a run longer than one; zero means no digits.
    if (cmd.run && (cmd.a_len > CW'(1))) begin
      cmd.a_ndig = DW'(1);
      for (int k = 1; k < ND; k++) begin
        if (cmd.a_len >= CW'(pow10(k))) begin
          cmd.a_ndig = DW'(k + 1);
        end
      end
    end
  end

  // Mode register and run state; a mode write clears the state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_COMPRESS;
      prev_r  <= '0;
      have_r  <= 1'b0;
      count_r <= '0;
    end else if (cfg_we) begin
      mode_r  <= cfg_mode;
      prev_r  <= '0;
      have_r  <= 1'b0;
      count_r <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      have_r  <= have_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/core/rltc_back.sv]
// Back part of the run-length text codec: takes commands from the queue and
// sends one result word a cycle while the output is not stalled, decimal digits first. Uses rltc_pkg.
module rltc_back
  import rltc_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF,
  parameter int CW      = $clog2(MAX_RUN + 1),
  parameter int ND      = num_digits(MAX_RUN),
  parameter int DW      = $clog2(ND + 1),
  parameter int CMD_W   = 18 + CW + DW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMD_W-1:0] head_data,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic [REP_W-1:0] out_repeat_res,
  output logic             out_last
);

  localparam int KW = (ND > 1) ? $clog2(ND) : 1;
  localparam int XW = CW + 4;

  typedef struct packed {
    logic          run;
    logic [7:0]    a_char;
    logic [CW-1:0] a_len;
    logic [DW-1:0] a_ndig;
    logic          b_valid;
    logic [7:0]    b_char;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DIGIT  = 3'b001,
    PH_CHAR_A = 3'b010,
    PH_CHAR_B = 3'b100
  } phase_t;

  cmd_t             head;
  logic             started_r;
  phase_t           ph_r, ph, ph_nxt;
  logic [CW-1:0]    rem_r, rem, rem_nxt;
  logic [KW-1:0]    k_r, k, k_nxt;
  logic [CW-1:0]    pw;
  logic [3:0]       dig;
  logic [XW-1:0]    sub;
  logic [7:0]       char_nxt;
  logic [REP_W-1:0] rep_nxt;
  logic             done;
  logic             advance;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic [REP_W-1:0] out_repeat_r;
  logic             out_last_r;

  assign head           = head_data;
  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_repeat_res = out_repeat_r;
  assign out_last       = out_last_r;

  // A fresh command takes its progress from the queue head.
  always_comb begin
    if (started_r) begin
      ph  = ph_r;
      rem = rem_r;
      k   = k_r;
    end else begin
      ph  = (head.a_ndig != '0) ? PH_DIGIT : PH_CHAR_A;
      rem = head.a_len;
      k   = KW'(head.a_ndig - DW'(1));
    end
  end

  // Weight of the current digit position.
  always_comb begin
    pw = CW'(1);
    for (int i = 0; i < ND; i++) begin
      if (k == KW'(i)) begin
        pw = CW'(pow10(i));
      end
    end
  end

  // Current digit: largest multiple of the weight that fits the remainder.
  always_comb begin
    dig = '0;
    sub = '0;
    for (int d = 1; d < 10; d++) begin
      if (XW'(rem) >= XW'(d) * XW'(pw)) begin
        dig = 4'(d);
        sub = XW'(d) * XW'(pw);
      end
    end
  end

  // Result word for the current step and the step after it.
  always_comb begin
    char_nxt = head.a_char;
    rep_nxt  = REP_W'(1);
    done     = 1'b1;
    ph_nxt   = PH_CHAR_A;
    rem_nxt  = rem;
    k_nxt    = k;
    case (ph)
      PH_DIGIT: begin
        char_nxt = CHAR_ZERO + {4'b0000, dig};
        done     = 1'b0;
        rem_nxt  = CW'(XW'(rem) - sub);
        k_nxt    = k - KW'(1);
        ph_nxt   = (k == '0) ? PH_CHAR_A : PH_DIGIT;
      end
      PH_CHAR_A: begin
        char_nxt = head.a_char;
        rep_nxt  = head.run ? REP_W'(1) : REP_W'(head.a_len);
        done     = !head.b_valid;
        ph_nxt   = PH_CHAR_B;
      end
      PH_CHAR_B: begin
        char_nxt = head.b_char;
        done     = 1'b1;
      end
      default: begin
        char_nxt = head.a_char;
        done     = 1'b1;
      end
    endcase
  end

  assign advance = head_valid && (!out_valid_r || !out_stall);
  assign pop     = advance && done;

  // Output register and progress through the current command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      ph_r        <= PH_CHAR_A;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      started_r   <= !done;
      ph_r        <= ph_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r   <= char_nxt;
      out_repeat_r <= rep_nxt;
      out_last_r   <= done;
      rem_r        <= rem_nxt;
      k_r          <= k_nxt;
    end
  end

endmodule

[rtl/core/run_length_text_codec.sv]
// Top level of the run-length text codec: APB-style register decode, front
// part, command queue and back part. Uses rltc_pkg and the rltc_* modules.
//
// The codec takes one text character per input word and, in compress mode,
// writes each run as its decimal length (left out for a run of one) and
// then the character; in expand mode, digits build a count, saturating at
// MAX_RUN, and a non-digit comes out once with that count as its repeat
// value. The front part accepts one input word every cycle while the
// command queue (QUEUE_DEPTH entries) has room; the back part sends one
// result word per cycle while the output is not stalled. An accepted word
// passes through the command queue and the output register before its
// first result appears. Register 0 (byte address 0) is the mode: 0 compress,
// 1 expand; writing it clears any open run or pending count. The user must
// write it only while the codec is idle; the block does not enforce this.
module run_length_text_codec
  import rltc_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_symbol,
  input  logic             in_line_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic [REP_W-1:0] out_repeat_res,
  output logic             out_last
);

  localparam int CW    = $clog2(MAX_RUN + 1);
  localparam int ND    = num_digits(MAX_RUN);
  localparam int DW    = $clog2(ND + 1);
  localparam int CMD_W = 18 + CW + DW;

  logic             mode_sel;
  logic             cfg_we;
  logic             mode;
  logic             q_push;
  logic [CMD_W-1:0] q_push_data;
  logic             q_pop;
  logic [CMD_W-1:0] q_head;
  logic             q_not_empty;
  logic             q_full;

  // Register decode: one 32-bit register, reads return the mode.
  assign cfg_pready = 1'b1;
  assign mode_sel   = (cfg_paddr[2] == 1'(REG_MODE));
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && mode_sel;
  assign cfg_prdata = mode_sel ? {31'b0, mode} : 32'b0;

  rltc_front #(
    .MAX_RUN (MAX_RUN),
    .CW      (CW),
    .ND      (ND),
    .DW      (DW),
    .CMD_W   (CMD_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_mode    (cfg_pwdata[0]),
    .mode        (mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_symbol   (in_symbol),
    .in_line_end (in_line_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  rltc_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rltc_back #(
    .MAX_RUN (MAX_RUN),
    .CW      (CW),
    .ND      (ND),
    .DW      (DW),
    .CMD_W   (CMD_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_data      (q_head),
    .head_valid     (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_repeat_res (out_repeat_res),
    .out_last       (out_last)
  );

endmodule
